@@ rtl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never hold outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

@@ rtl/njs_pkg.sv @@
// Types and constants shared by the job scheduler modules.
package njs_pkg;

	localparam int ID_W   = 8;
	localparam int NEED_W = 16;
	localparam int OUT_W  = 16;

	typedef enum logic {
		CMD_ARRIVE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		POL_FCFS   = 2'd0,
		POL_SJF    = 2'd1,
		POL_HRRN   = 2'd2,
		POL_UNUSED = 2'd3	// decodes as FCFS
	} policy_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_PREP,
		S_MUL_L,
		S_MUL_R,
		S_CMP,
		S_DISPATCH,
		S_RESULT
	} state_t;

	// Sequencer strobes into the ranking unit
	typedef struct packed {
		logic load_lhs;
		logic load_rhs;
	} rank_ctl_t;

	// One result transaction
	typedef struct packed {
		logic              accepted;
		logic              running_valid;
		logic [ID_W-1:0]   running_id;
		logic              done_valid;
		logic [ID_W-1:0]   done_id;
		logic [OUT_W-1:0]  finish_time;
		logic [OUT_W-1:0]  turnaround;
		logic [NEED_W-1:0] done_need;
	} rsp_t;

endpackage

@@ rtl/njs_req_if.sv @@
// Request channel: arrive or tick commands into the scheduler.
interface njs_req_if;
	logic                        valid;
	logic                        ready;
	njs_pkg::cmd_t               cmd;
	logic [njs_pkg::ID_W-1:0]    job_id;
	logic [njs_pkg::NEED_W-1:0]  service_need;

	modport source (output valid, cmd, job_id, service_need, input ready);
	modport sink   (input valid, cmd, job_id, service_need, output ready);
endinterface

@@ rtl/njs_rsp_if.sv @@
// Response channel: one result per accepted command.
interface njs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic                        running_valid;
	logic [njs_pkg::ID_W-1:0]    running_id;
	logic                        done_valid;
	logic [njs_pkg::ID_W-1:0]    done_id;
	logic [njs_pkg::OUT_W-1:0]   finish_time;
	logic [njs_pkg::OUT_W-1:0]   turnaround;
	logic [njs_pkg::NEED_W-1:0]  done_need;

	modport source (output valid, accepted, running_valid, running_id, done_valid, done_id,
		finish_time, turnaround, done_need, input ready);
	modport sink   (input valid, accepted, running_valid, running_id, done_valid, done_id,
		finish_time, turnaround, done_need, output ready);
endinterface

@@ rtl/njs_slot_mem.sv @@
// Ready-queue storage: id, arrival time and need per slot, one write and one registered read port.
module njs_slot_mem #(
	parameter int DEPTH     = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [njs_pkg::ID_W-1:0]     wid,
	input  logic [TIME_BITS-1:0]         warr,
	input  logic [njs_pkg::NEED_W-1:0]   wneed,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [njs_pkg::ID_W-1:0]     rid,
	output logic [TIME_BITS-1:0]         rarr,
	output logic [njs_pkg::NEED_W-1:0]   rneed
);
	import njs_pkg::*;

	logic [ID_W-1:0]      id_mem   [DEPTH];
	logic [TIME_BITS-1:0] arr_mem  [DEPTH];
	logic [NEED_W-1:0]    need_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[waddr]   <= wid;
			arr_mem[waddr]  <= warr;
			need_mem[waddr] <= wneed;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rid   <= id_mem[raddr];
		rarr  <= arr_mem[raddr];
		rneed <= need_mem[raddr];
	end
endmodule

@@ rtl/njs_rank_unit.sv @@
// Shared ranking unit: one multiplier for the response-ratio cross products and the comparator.
module njs_rank_unit #(
	parameter int TIME_BITS = 16
) (
	input  logic                          clk,
	input  njs_pkg::rank_ctl_t            ctl,
	input  logic [1:0]                    policy,
	input  logic [TIME_BITS-1:0]          cand_wait,
	input  logic [((TIME_BITS > njs_pkg::NEED_W) ? TIME_BITS : njs_pkg::NEED_W):0] cand_sum,
	input  logic [njs_pkg::NEED_W-1:0]    cand_need,
	input  logic [TIME_BITS-1:0]          best_wait,
	input  logic [((TIME_BITS > njs_pkg::NEED_W) ? TIME_BITS : njs_pkg::NEED_W):0] best_sum,
	input  logic [njs_pkg::NEED_W-1:0]    best_need,
	output logic                          better
);
	import njs_pkg::*;

	localparam int SUM_W  = ((TIME_BITS > NEED_W) ? TIME_BITS : NEED_W) + 1;
	localparam int PROD_W = SUM_W + NEED_W;

	logic [SUM_W-1:0]  mul_a;
	logic [NEED_W-1:0] mul_b;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] lhs_q;
	logic [PROD_W-1:0] rhs_q;
	logic              wait_gt;

	// operand select: (wc+nc)*nb first, then (wb+nb)*nc
	assign mul_a = ctl.load_lhs ? cand_sum : best_sum;
	assign mul_b = ctl.load_lhs ? best_need : cand_need;
	assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (ctl.load_lhs) begin
			lhs_q <= prod;
		end
		if (ctl.load_rhs) begin
			rhs_q <= prod;
		end
	end

	// longer wait breaks every tie
	assign wait_gt = cand_wait > best_wait;

	always_comb begin
		case (policy)
			POL_SJF: begin
				better = (cand_need != best_need) ? (cand_need < best_need) : wait_gt;
			end
			POL_HRRN: begin
				better = (lhs_q != rhs_q) ? (lhs_q > rhs_q) : wait_gt;
			end
			default: begin
				better = wait_gt;
			end
		endcase
	end
endmodule

@@ rtl/nonpreemptive_job_scheduler.sv @@
// Non-preemptive FCFS / SJF / HRRN job scheduler driven by arrive and tick transactions.
// Arrive, or tick that keeps a running job: result registered once the output register is
// free, next transaction accepted after that. Tick with an idle or retiring processor: one
// pass over all slots with a single comparator; an empty slot takes READ, a filled one READ,
// PREP, CMP (and MUL_L, MUL_R under HRRN once a best exists), then DISPATCH and RESULT.
// Async reset clears control, time, running job and slot valid bits; slot contents are not reset.
`include "assert_macros.svh"
module nonpreemptive_job_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             policy_we,
	input  logic [1:0]       policy_wdata,
	njs_req_if.sink          req,
	njs_rsp_if.source        rsp
);
	import njs_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int SUM_W = ((TIME_BITS > NEED_W) ? TIME_BITS : NEED_W) + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	state_t                 state_q, state_d;
	logic [1:0]             policy_q;
	logic [QUEUE_DEPTH-1:0] slot_valid_q;
	logic [TIME_BITS-1:0]   now_q;
	logic                   busy_q;
	logic [ID_W-1:0]        cur_id_q;
	logic [TIME_BITS-1:0]   cur_arr_q;
	logic [NEED_W-1:0]      cur_need_q;
	logic [NEED_W-1:0]      cur_used_q;
	logic [IDX_W-1:0]       scan_idx_q;
	logic                   found_q;
	logic                   out_valid_q;
	rsp_t                   out_q;

	// candidate and best-so-far registers
	logic [TIME_BITS-1:0]   cand_wait_q;
	logic [SUM_W-1:0]       cand_sum_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic [ID_W-1:0]        best_id_q;
	logic [TIME_BITS-1:0]   best_arr_q;
	logic [NEED_W-1:0]      best_need_q;
	logic [TIME_BITS-1:0]   best_wait_q;
	logic [SUM_W-1:0]       best_sum_q;

	// pending result fields
	logic                   res_accepted_q;
	logic                   res_done_valid_q;
	logic [ID_W-1:0]        res_done_id_q;
	logic [OUT_W-1:0]       res_finish_q;
	logic [OUT_W-1:0]       res_turn_q;
	logic [NEED_W-1:0]      res_need_q;

	logic                   acc;
	logic                   is_tick;
	logic                   retire;
	logic                   has_free;
	logic [IDX_W-1:0]       free_idx;
	logic                   scan_last;
	logic                   take;
	logic                   better;
	logic                   load_out;
	logic [NEED_W-1:0]      wneed;
	logic [TIME_BITS-1:0]   prep_wait;
	rank_ctl_t              rank_ctl;
	logic [ID_W-1:0]        rd_id;
	logic [TIME_BITS-1:0]   rd_arr;
	logic [NEED_W-1:0]      rd_need;

	// command decode
	assign acc       = req.valid && req.ready;
	assign is_tick   = (req.cmd == CMD_TICK);
	assign retire    = busy_q && (cur_used_q >= cur_need_q);
	assign has_free  = ~&slot_valid_q;
	assign scan_last = (scan_idx_q == LAST_IDX);
	assign take      = !found_q || better;
	assign load_out  = (state_q == S_RESULT) && (!out_valid_q || rsp.ready);
	assign wneed     = (req.service_need == '0) ? NEED_W'(1) : req.service_need;
	assign prep_wait = now_q - rd_arr;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	njs_slot_mem #(
		.DEPTH     (QUEUE_DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_mem (
		.clk   (clk),
		.we    (acc && !is_tick && has_free),
		.waddr (free_idx),
		.wid   (req.job_id),
		.warr  (now_q),
		.wneed (wneed),
		.raddr (scan_idx_q),
		.rid   (rd_id),
		.rarr  (rd_arr),
		.rneed (rd_need)
	);

	njs_rank_unit #(
		.TIME_BITS (TIME_BITS)
	) u_rank (
		.clk       (clk),
		.ctl       (rank_ctl),
		.policy    (policy_q),
		.cand_wait (cand_wait_q),
		.cand_sum  (cand_sum_q),
		.cand_need (rd_need),
		.best_wait (best_wait_q),
		.best_sum  (best_sum_q),
		.best_need (best_need_q),
		.better    (better)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (is_tick && !(busy_q && !retire)) begin
						state_d = S_READ;
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_READ: begin
				if (slot_valid_q[scan_idx_q]) begin
					state_d = S_PREP;
				end else if (scan_last) begin
					state_d = S_DISPATCH;
				end
			end
			S_PREP: begin
				state_d = (found_q && policy_q == POL_HRRN) ? S_MUL_L : S_CMP;
			end
			S_MUL_L:    state_d = S_MUL_R;
			S_MUL_R:    state_d = S_CMP;
			S_CMP: begin
				state_d = scan_last ? S_DISPATCH : S_READ;
			end
			S_DISPATCH: state_d = S_RESULT;
			S_RESULT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready         = (state_q == S_IDLE);
		rank_ctl.load_lhs = (state_q == S_MUL_L);
		rank_ctl.load_rhs = (state_q == S_MUL_R);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			policy_q     <= POL_FCFS;
			slot_valid_q <= '0;
			now_q        <= '0;
			busy_q       <= 1'b0;
			cur_id_q     <= '0;
			cur_arr_q    <= '0;
			cur_need_q   <= '0;
			cur_used_q   <= '0;
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (policy_we) begin
				policy_q <= policy_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (acc && is_tick) begin
						scan_idx_q <= '0;
						found_q    <= 1'b0;
						if (retire) begin
							busy_q <= 1'b0;
						end else if (busy_q) begin
							now_q      <= now_q + TIME_BITS'(1);
							cur_used_q <= cur_used_q + NEED_W'(1);
						end
					end else if (acc && has_free) begin
						slot_valid_q[free_idx] <= 1'b1;
					end
				end
				S_READ: begin
					if (!slot_valid_q[scan_idx_q] && !scan_last) begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_CMP: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (!scan_last) begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_DISPATCH: begin
					now_q <= now_q + TIME_BITS'(1);
					if (found_q) begin
						slot_valid_q[best_idx_q] <= 1'b0;
						busy_q     <= 1'b1;
						cur_id_q   <= best_id_q;
						cur_arr_q  <= best_arr_q;
						cur_need_q <= best_need_q;
						cur_used_q <= NEED_W'(1);
					end
				end
				default: begin
				end
			endcase
			// output register handshake
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc && is_tick) begin
					res_accepted_q   <= 1'b1;
					res_done_valid_q <= retire;
					res_done_id_q    <= retire ? cur_id_q : '0;
					res_finish_q     <= retire ? OUT_W'(now_q) : '0;
					res_turn_q       <= retire ? (OUT_W'(now_q) - OUT_W'(cur_arr_q)) : '0;
					res_need_q       <= retire ? cur_need_q : '0;
				end else if (acc) begin
					res_accepted_q   <= has_free;
					res_done_valid_q <= 1'b0;
					res_done_id_q    <= '0;
					res_finish_q     <= '0;
					res_turn_q       <= '0;
					res_need_q       <= '0;
				end
			end
			S_PREP: begin
				cand_wait_q <= prep_wait;
				cand_sum_q  <= SUM_W'(prep_wait) + SUM_W'(rd_need);
			end
			S_CMP: begin
				if (take) begin
					best_idx_q  <= scan_idx_q;
					best_id_q   <= rd_id;
					best_arr_q  <= rd_arr;
					best_need_q <= rd_need;
					best_wait_q <= cand_wait_q;
					best_sum_q  <= cand_sum_q;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_q.accepted      <= res_accepted_q;
			out_q.running_valid <= busy_q;
			out_q.running_id    <= busy_q ? cur_id_q : '0;
			out_q.done_valid    <= res_done_valid_q;
			out_q.done_id       <= res_done_id_q;
			out_q.finish_time   <= res_finish_q;
			out_q.turnaround    <= res_turn_q;
			out_q.done_need     <= res_need_q;
		end
	end

	// response port
	assign rsp.valid         = out_valid_q;
	assign rsp.accepted      = out_q.accepted;
	assign rsp.running_valid = out_q.running_valid;
	assign rsp.running_id    = out_q.running_id;
	assign rsp.done_valid    = out_q.done_valid;
	assign rsp.done_id       = out_q.done_id;
	assign rsp.finish_time   = out_q.finish_time;
	assign rsp.turnaround    = out_q.turnaround;
	assign rsp.done_need     = out_q.done_need;

	// a running job always has a nonzero need
	`ASSERT_PROP(a_need_nonzero, busy_q |-> (cur_need_q != '0), "running job with zero need")
	// the dispatched slot is still occupied at dispatch
	`ASSERT_PROP(a_best_valid, (state_q == S_DISPATCH) && found_q |-> slot_valid_q[best_idx_q], "dispatching an empty slot")
	// dispatch frees exactly one slot
	`ASSERT_PROP(a_dispatch_pop, (state_q == S_DISPATCH) && found_q |=> ($countones(slot_valid_q) + 1 == $past($countones(slot_valid_q))), "dispatch did not free one slot")
	// a blocked result keeps the sequencer waiting
	`ASSERT_PROP(a_result_hold, (state_q == S_RESULT) && out_valid_q && !rsp.ready |=> (state_q == S_RESULT), "result dropped while output full")
endmodule

@@ bench/schedule_checker.sv @@
// Scoreboard for the job scheduler: mirrors its ready queue and clock, checks every result.
module schedule_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       policy_we,
	input  logic [1:0] policy_wdata,
	njs_req_if         req,
	njs_rsp_if         rsp,
	output int         fail_count,
	output int         outstanding,
	output int         retired,
	output int         refused
);
	import njs_pkg::*;

	// Mirror of the scheduler state
	logic [1:0]        policy;
	logic              slot_live   [QUEUE_DEPTH];
	logic [ID_W-1:0]   slot_job    [QUEUE_DEPTH];
	logic [15:0]       slot_arrive [QUEUE_DEPTH];
	logic [NEED_W-1:0] slot_len    [QUEUE_DEPTH];
	logic [15:0]       now_tick;
	logic              cpu_busy;
	logic [ID_W-1:0]   run_job;
	logic [15:0]       run_arrive;
	logic [NEED_W-1:0] run_len;
	logic [15:0]       run_used;

	// Predicted results, oldest first
	rsp_t expected_q[$];

	// True if slot a beats slot b; falls back to longer wait, then to the caller's scan order
	function automatic bit outranks(int a, int b);
		logic [15:0] wa, wb;
		logic [63:0] lhs, rhs;
		wa = now_tick - slot_arrive[a];
		wb = now_tick - slot_arrive[b];
		if (policy == POL_SJF) begin
			if (slot_len[a] != slot_len[b])
				return slot_len[a] < slot_len[b];
		end else if (policy == POL_HRRN) begin
			// (wait+need)/need compared without division
			lhs = (64'(wa) + 64'(slot_len[a])) * 64'(slot_len[b]);
			rhs = (64'(wb) + 64'(slot_len[b])) * 64'(slot_len[a]);
			if (lhs != rhs)
				return lhs > rhs;
		end
		return wa > wb;
	endfunction

	// Apply one command to the mirror and return the result it must produce
	function automatic rsp_t next_schedule(cmd_t op, logic [ID_W-1:0] id,
			logic [NEED_W-1:0] need_in);
		rsp_t r;
		logic [NEED_W-1:0] need;
		int best;
		bit found;
		int i;
		r = '0;
		found = 1'b0;
		best = 0;
		if (op == CMD_ARRIVE) begin
			// zero need is stored as one tick
			need = (need_in == '0) ? NEED_W'(1) : need_in;
			for (i = 0; i < QUEUE_DEPTH; i++) begin
				if (!slot_live[i]) begin
					slot_live[i] = 1'b1;
					slot_job[i] = id;
					slot_arrive[i] = now_tick;
					slot_len[i] = need;
					r.accepted = 1'b1;
					break;
				end
			end
		end else begin
			r.accepted = 1'b1;
			// retire a job that has used its full need
			if (cpu_busy && run_used >= run_len) begin
				r.done_valid = 1'b1;
				r.done_id = run_job;
				r.finish_time = now_tick;
				r.turnaround = now_tick - run_arrive;
				r.done_need = run_len;
				cpu_busy = 1'b0;
			end
			// dispatch the best ready job onto an idle processor
			if (!cpu_busy) begin
				for (i = 0; i < QUEUE_DEPTH; i++) begin
					if (slot_live[i] && (!found || outranks(i, best))) begin
						best = i;
						found = 1'b1;
					end
				end
				if (found) begin
					slot_live[best] = 1'b0;
					cpu_busy = 1'b1;
					run_job = slot_job[best];
					run_arrive = slot_arrive[best];
					run_len = slot_len[best];
					run_used = '0;
				end
			end
			now_tick = now_tick + 16'd1;
			if (cpu_busy)
				run_used = run_used + 16'd1;
		end
		r.running_valid = cpu_busy;
		r.running_id = cpu_busy ? run_job : '0;
		return r;
	endfunction

	function automatic string fmt_rsp(rsp_t r);
		return $sformatf("acc=%0d run=%0d/%0d done=%0d id=%0d fin=%0d tat=%0d need=%0d",
			r.accepted, r.running_valid, r.running_id, r.done_valid, r.done_id,
			r.finish_time, r.turnaround, r.done_need);
	endfunction

	// Track configuration and transactions on both channels
	always @(posedge clk or negedge arst_n) begin
		rsp_t got, want;
		int i;
		if (!arst_n) begin
			policy = POL_FCFS;
			for (i = 0; i < QUEUE_DEPTH; i++)
				slot_live[i] = 1'b0;
			now_tick = '0;
			cpu_busy = 1'b0;
			run_job = '0;
			run_arrive = '0;
			run_len = '0;
			run_used = '0;
			expected_q.delete();
			fail_count = 0;
			outstanding = 0;
			retired = 0;
			refused = 0;
		end else begin
			if (policy_we)
				policy = policy_wdata;
			// command transaction: predict its result
			if (req.valid && req.ready)
				expected_q.push_back(next_schedule(req.cmd, req.job_id, req.service_need));
			// result transaction: compare with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				got.accepted = rsp.accepted;
				got.running_valid = rsp.running_valid;
				got.running_id = rsp.running_id;
				got.done_valid = rsp.done_valid;
				got.done_id = rsp.done_id;
				got.finish_time = rsp.finish_time;
				got.turnaround = rsp.turnaround;
				got.done_need = rsp.done_need;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result at %0t: %s", $time, fmt_rsp(got));
				end else begin
					want = expected_q.pop_front();
					if (want.done_valid)
						retired++;
					if (!want.accepted)
						refused++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch at %0t\n  expected %s\n  actual   %s",
								$time, fmt_rsp(want), fmt_rsp(got));
					end
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
// Top of the scheduler bench: clock, reset, stimulus phases, watchdog and verdict.
module testbench;
	import njs_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int SEG_ITEMS   = 70;

	logic       clk;
	logic       arst_n;
	logic       policy_we;
	logic [1:0] policy_wdata;
	int         fail_count;
	int         outstanding;
	int         retired;
	int         refused;
	int         src_idle;
	int         dst_idle;
	int         arrivals;
	int         ticks;
	int         quiet_cycles;

	logic [1:0] seg_policy [6];

	njs_req_if req_ch ();
	njs_rsp_if rsp_ch ();

	nonpreemptive_job_scheduler DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.policy_we    (policy_we),
		.policy_wdata (policy_wdata),
		.req          (req_ch),
		.rsp          (rsp_ch)
	);

	schedule_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.policy_we    (policy_we),
		.policy_wdata (policy_wdata),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.retired      (retired),
		.refused      (refused)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random back-pressure on the result channel
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= dst_idle);
	end

	// Watchdog: too long without any transaction
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One command transaction, with random idle cycles ahead of it
	task automatic send_item(cmd_t op, logic [ID_W-1:0] id, logic [NEED_W-1:0] need);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.job_id <= id;
		req_ch.service_need <= need;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (op == CMD_ARRIVE)
			arrivals++;
		else
			ticks++;
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Policy writes only while nothing is in flight
	task automatic set_policy(logic [1:0] p);
		drain();
		policy_we <= 1'b1;
		policy_wdata <= p;
		@(negedge clk);
		policy_we <= 1'b0;
	endtask

	// Job traffic with an arrival rate that drifts, so the queue both empties and fills
	task automatic random_run(int count);
		int arr_pct;
		int k;
		logic [NEED_W-1:0] need;
		arr_pct = 40;
		for (k = 0; k < count; k++) begin
			if (k % 20 == 0)
				arr_pct = $urandom_range(15, 65);
			if ($urandom_range(0, 99) < arr_pct) begin
				case ($urandom_range(0, 9))
					0: need = '0;
					1: need = NEED_W'($urandom_range(9, 24));
					default: need = NEED_W'($urandom_range(1, 8));
				endcase
				send_item(CMD_ARRIVE, ID_W'($urandom), need);
			end else begin
				// job fields are don't-care on a tick; send noise
				send_item(CMD_TICK, ID_W'($urandom), NEED_W'($urandom));
			end
		end
	endtask

	initial begin
		int i;
		arst_n = 1'b0;
		policy_we = 1'b0;
		policy_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_TICK;
		req_ch.job_id = '0;
		req_ch.service_need = '0;
		arrivals = 0;
		ticks = 0;
		src_idle = 30;
		dst_idle = 47;
		seg_policy = '{POL_SJF, POL_HRRN, POL_UNUSED, POL_FCFS, POL_HRRN, POL_SJF};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed: tick on an empty queue, fill all slots at one time stamp, overflow, then ticks
		send_item(CMD_TICK, 8'h00, 16'h0000);
		for (i = 0; i < 16; i++)
			send_item(CMD_ARRIVE, (i == 1) ? 8'hFF : ID_W'(8'h11 * i),
				(i == 0) ? 16'd0 : NEED_W'(1 + i % 3));
		send_item(CMD_ARRIVE, 8'hAA, 16'd1);
		repeat (7) send_item(CMD_TICK, 8'h00, 16'h0000);

		// Random segments under each policy code and pacing mode
		for (i = 0; i < 6; i++) begin
			set_policy(seg_policy[i]);
			if (i == 2) begin
				src_idle = 47;
				dst_idle = 30;
			end else if (i == 4) begin
				src_idle = 0;
				dst_idle = 0;
			end
			random_run(SEG_ITEMS);
		end

		drain();
		repeat (20) @(negedge clk);
		$display("run covered %0d arrivals (%0d refused on a full queue), %0d ticks, %0d jobs done",
			arrivals, refused, ticks, retired);
		$display("all four policy codes, three pacing modes, a full queue and an overflow");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
